### rtl/core/disk_block_sector_address_gen_macros.svh
// Assertion macros used by the checker file of the sector address generator.
// Every macro samples on the rising edge of clk; no other dependencies.
`ifndef DISK_BLOCK_SECTOR_ADDRESS_GEN_MACROS_SVH
`define DISK_BLOCK_SECTOR_ADDRESS_GEN_MACROS_SVH

// Concurrent assertion that is switched off while rst is high.
`define DBSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while rst is high.
`define DBSA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/dbsa_pkg.sv
// Package of the disk block sector address generator: widths, codes and shared types.
// Used by dbsa_regs, dbsa_alu and the top level; depends on nothing.
package dbsa_pkg;

  localparam int MAX_SECTORS_PER_TRACK = 64;
  localparam int SKEW_AW   = $clog2(MAX_SECTORS_PER_TRACK);
  localparam int SKEW_W    = 8;
  localparam int CFG_W     = 7;
  localparam int RT_W      = 8;
  localparam int BLOCK_W   = 16;
  localparam int COUNT_W   = 8;
  localparam int TRACK_W   = 23;
  localparam int SECT_W    = 6;
  localparam int CMD_W     = 2;
  localparam int DATA_W    = 40;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int COUNT_LIMIT = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SKEW  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SPT = 2'd0,
    REG_RT  = 2'd1,
    REG_SPB = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] spt;
    logic [RT_W-1:0]  rt;
    logic [CFG_W-1:0] spb;
  } cfg_t;

  typedef struct packed {
    logic               sub;
    logic [TRACK_W-1:0] a;
    logic [TRACK_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               carry;
    logic [TRACK_W-1:0] sum;
  } alu_rsp_t;

endpackage

### rtl/core/dbsa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; sized by its WIDTH and DEPTH parameters.
module dbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/dbsa_alu.sv
// Shared add/subtract unit used for the multiply, divide and track-step steps.
// Depends on dbsa_pkg for the request and response structs.
module dbsa_alu
  import dbsa_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [TRACK_W:0] wide;

  // For a subtract, carry set means a >= b (no borrow).
  always_comb begin
    if (req.sub) begin
      wide = {1'b0, req.a} + {1'b0, ~req.b} + {{TRACK_W{1'b0}}, 1'b1};
    end else begin
      wide = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.carry = wide[TRACK_W];
    rsp.sum   = wide[TRACK_W-1:0];
  end

endmodule

### rtl/core/dbsa_regs.sv
// APB configuration registers: sectors per track, reserved tracks, sectors per block.
// Depends on dbsa_pkg for the register codes and the cfg_t struct.
module dbsa_regs
  import dbsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spt <= CFG_W'(26);
      cfg.rt  <= RT_W'(2);
      cfg.spb <= CFG_W'(8);
    end else if (wr_en) begin
      unique case (idx)
        REG_SPT: cfg.spt <= pwdata[CFG_W-1:0];
        REG_RT:  cfg.rt  <= pwdata[RT_W-1:0];
        REG_SPB: cfg.spb <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPT: prdata = APB_DW'(cfg.spt);
      REG_RT:  prdata = APB_DW'(cfg.rt);
      REG_SPB: prdata = APB_DW'(cfg.spb);
      default: prdata = '0;
    endcase
  end

endmodule

### rtl/core/disk_block_sector_address_gen.sv
// Top level of the disk block sector address generator: sequencer and datapath.
// Depends on dbsa_pkg, dbsa_regs, dbsa_alu and dbsa_ram.
//
// Usage. Requests arrive as words on the s_ channel; s_tuser carries the command
// (read, write or skew load). A skew load writes one entry of the skew table in
// the cycle it is accepted and produces nothing. A read or write request turns
// into a run of sector addresses on the m_ channel, one word per sector, with
// m_tlast on the final one and m_tuser set for a write. A count of zero, and the
// unused command code, produce no word at all.
// Timing. The linear sector is formed by two 7-step shift-and-add multiplies and
// then split into track and sector by a 23-step restoring divide, all on one
// shared adder. After the divide the block reads the skew table (registered) and
// then offers the first address; after each further address is taken it reads
// the table again before offering the next. s_tready is low for the whole request.
// Stalls. A word on m_ holds with all its fields until m_tready is seen; the
// sequencer simply waits. Reset (rst, synchronous) returns the sequencer to idle
// and the registers to 26 sectors per track, 2 reserved tracks and 8 sectors
// per block. The skew table is not cleared and must be loaded before use.
module disk_block_sector_address_gen
  import dbsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // s_tdata, lowest bit up: block_number[15:0], sector_count[23:16],
  // skew_index[29:24], skew_value[37:30], zero fill.
  input  logic [DATA_W-1:0] s_tdata,
  // s_tuser: cmd[1:0].
  input  logic [CMD_W-1:0]  s_tuser,
  input  logic              s_tvalid,
  output logic              s_tready,
  // m_tdata, lowest bit up: track[22:0], phys_sector[30:23],
  // sector_in_block[36:31], zero fill.
  output logic [DATA_W-1:0] m_tdata,
  // m_tuser: is_write.
  output logic              m_tuser,
  output logic              m_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV,
    ST_RD,
    ST_OUT
  } state_t;

  localparam int STEP_W = $clog2(TRACK_W);

  state_t             state;
  cfg_t               cfg;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  logic               is_wr;
  logic [TRACK_W-1:0] acc;
  logic [TRACK_W-1:0] mcand;
  logic [CFG_W-1:0]   mplier;
  logic [SECT_W-1:0]  rem;
  logic [STEP_W-1:0]  step;
  logic [SECT_W-1:0]  count_m1;
  logic [SECT_W-1:0]  k;
  logic [SECT_W-1:0]  sect;
  logic [TRACK_W-1:0] track;

  logic [CFG_W-1:0]   spt_eff;
  logic [CFG_W-1:0]   count;
  logic [COUNT_W-1:0] cnt_raw;
  logic [CFG_W-1:0]   trial;
  logic [SECT_W-1:0]  rem_next;
  logic [TRACK_W-1:0] acc_next;
  logic               s_acc;
  logic               m_acc;
  logic               is_last;
  logic               wraps;
  logic               skew_we;
  logic [SKEW_W-1:0]  skew_q;

  assign pready = 1'b1;

  dbsa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dbsa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // The skew table is only written from idle and only read in ST_RD.
  assign skew_we = s_acc && (cmd_t'(s_tuser) == CMD_SKEW)
                   && (32'(s_tdata[29:24]) < MAX_SECTORS_PER_TRACK);

  dbsa_ram #(
    .WIDTH (SKEW_W),
    .DEPTH (MAX_SECTORS_PER_TRACK)
  ) u_skew (
    .clk   (clk),
    .we    (skew_we),
    .waddr (SKEW_AW'(s_tdata[29:24])),
    .wdata (s_tdata[37:30]),
    .re    (state == ST_RD),
    .raddr (SKEW_AW'(sect)),
    .rdata (skew_q)
  );

  // Sectors per track is clamped to 1..64 for the multiply, the divide and the wrap.
  always_comb begin
    if (cfg.spt == '0) begin
      spt_eff = CFG_W'(1);
    end else if (32'(cfg.spt) > MAX_SECTORS_PER_TRACK) begin
      spt_eff = CFG_W'(MAX_SECTORS_PER_TRACK);
    end else begin
      spt_eff = cfg.spt;
    end
  end

  // A negative count asks for one full block; either way it saturates at 64.
  assign cnt_raw = s_tdata[23:16];
  always_comb begin
    if (cnt_raw[COUNT_W-1]) begin
      count = cfg.spb;
    end else begin
      count = cnt_raw[CFG_W-1:0];
    end
    if (32'(count) > COUNT_LIMIT) begin
      count = CFG_W'(COUNT_LIMIT);
    end
  end

  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;
  assign is_last  = (k == count_m1);
  assign wraps    = (CFG_W'(sect) + CFG_W'(1)) >= spt_eff;

  // One restoring divide step: shift the next dividend bit into the remainder.
  assign trial    = {rem, acc[TRACK_W-1]};
  assign rem_next = alu_rsp.carry ? alu_rsp.sum[SECT_W-1:0] : trial[SECT_W-1:0];
  assign acc_next = {acc[TRACK_W-2:0], alu_rsp.carry};

  // Operand selection for the shared adder.
  always_comb begin
    alu_req.sub = 1'b0;
    alu_req.a   = acc;
    alu_req.b   = mplier[0] ? mcand : '0;
    unique case (state) inside
      ST_MUL_A, ST_MUL_B: begin
        alu_req.sub = 1'b0;
        alu_req.a   = acc;
        alu_req.b   = mplier[0] ? mcand : '0;
      end
      ST_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = TRACK_W'(trial);
        alu_req.b   = TRACK_W'(spt_eff);
      end
      ST_OUT: begin
        alu_req.sub = 1'b0;
        alu_req.a   = track;
        alu_req.b   = TRACK_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state) inside
        ST_IDLE: begin
          if (s_acc) begin
            is_wr    <= s_tuser[0];
            acc      <= '0;
            mcand    <= TRACK_W'(s_tdata[BLOCK_W-1:0]);
            mplier   <= cfg.spb;
            step     <= '0;
            count_m1 <= SECT_W'(count - CFG_W'(1));
            unique case (cmd_t'(s_tuser)) inside
              CMD_READ, CMD_WRITE: begin
                if (count != '0) begin
                  state <= ST_MUL_A;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL_A, ST_MUL_B: begin
          acc    <= alu_rsp.sum;
          mcand  <= {mcand[TRACK_W-2:0], 1'b0};
          mplier <= mplier >> 1;
          step   <= step + STEP_W'(1);
          if (32'(step) == CFG_W - 1) begin
            step <= '0;
            if (state == ST_MUL_A) begin
              mcand  <= TRACK_W'(cfg.rt);
              mplier <= spt_eff;
              state  <= ST_MUL_B;
            end else begin
              rem   <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          acc  <= acc_next;
          step <= step + STEP_W'(1);
          if (32'(step) == TRACK_W - 1) begin
            track <= acc_next;
            sect  <= rem_next;
            k     <= '0;
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_acc) begin
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              k <= k + SECT_W'(1);
              if (wraps) begin
                sect  <= '0;
                track <= alu_rsp.sum;
              end else begin
                sect <= sect + SECT_W'(1);
              end
              state <= ST_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tlast  = is_last;
  assign m_tuser  = is_wr;
  assign m_tdata  = {(DATA_W - TRACK_W - SKEW_W - SECT_W)'(0), k, skew_q, track};

endmodule

### rtl/core/dbsa_checker.sv
// Port-level checker for the disk block sector address generator, bound to its top level.
// Depends on disk_block_sector_address_gen_macros.svh for the assertion macros.
`include "disk_block_sector_address_gen_macros.svh"

module dbsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast,
  input logic        m_tvalid,
  input logic        m_tready
);

  // A stalled output word keeps all of its fields.
  `DBSA_ASSERT(a_out_hold,
               m_tvalid && !m_tready |=> m_tvalid && $stable({m_tuser, m_tlast, m_tdata}),
               "output word changed while stalled")

  // The block works on one request at a time: no intake while a word is offered.
  `DBSA_ASSERT(a_one_at_a_time, !(s_tready && m_tvalid), "input ready while output valid")

  // Every address costs a skew table read, so words never come back to back.
  `DBSA_ASSERT(a_word_gap, m_tvalid && m_tready |=> !m_tvalid, "output words back to back")

  // Reset leaves the block idle and ready for a request.
  `DBSA_ASSERT_RST(a_reset_idle, rst |=> s_tready && !m_tvalid, "not idle after reset")

endmodule

bind disk_block_sector_address_gen dbsa_checker u_dbsa_checker (.*);

### verif/disk_block_sector_address_gen_checker.sv
// Checker for the disk block sector address generator: watches the request, result and
// register ports, predicts every sector address word and compares it field by field.
// Depends on dbsa_pkg for widths, command codes and register indexes.
module disk_block_sector_address_gen_checker
  import dbsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic [CMD_W-1:0]  s_tuser,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DATA_W-1:0] m_tdata,
  input  logic              m_tuser,
  input  logic              m_tlast,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output int                checked
);

  typedef struct packed {
    logic               is_write;
    logic [TRACK_W-1:0] track;
    logic [SKEW_W-1:0]  phys_sector;
    logic [SECT_W-1:0]  sector_in_block;
    logic               last;
  } sector_addr_t;

  // Shadow copy of the registers and of the skew table.
  int unsigned       spt_cfg;
  int unsigned       rt_cfg;
  int unsigned       spb_cfg;
  logic [SKEW_W-1:0] skew_shadow [MAX_SECTORS_PER_TRACK];

  sector_addr_t sector_addr_q [$];
  sector_addr_t got;
  sector_addr_t want;
  int           errors;
  int           seen;

  // Expands one read or write request into its run of sector addresses.
  task automatic expand_request(input logic is_wr, input logic [BLOCK_W-1:0] blk,
                                input logic [COUNT_W-1:0] cnt_raw);
    int unsigned  spt;
    int unsigned  count;
    int unsigned  linear;
    int unsigned  trk;
    int unsigned  sect;
    int unsigned  k;
    sector_addr_t a;
    count = cnt_raw[COUNT_W-1] ? spb_cfg : int'(cnt_raw);
    if (count > COUNT_LIMIT) count = COUNT_LIMIT;
    // The divisor and the wrap point both use the clamped sectors-per-track.
    spt = (spt_cfg < 1) ? 1 : (spt_cfg > MAX_SECTORS_PER_TRACK) ?
          MAX_SECTORS_PER_TRACK : spt_cfg;
    linear = int'(blk) * spb_cfg + rt_cfg * spt;
    trk  = linear / spt;
    sect = linear % spt;
    for (k = 0; k < count; k++) begin
      a.is_write        = is_wr;
      a.track           = trk[TRACK_W-1:0];
      a.phys_sector     = skew_shadow[sect];
      a.sector_in_block = k[SECT_W-1:0];
      a.last            = (k + 1 == count);
      sector_addr_q.push_back(a);
      sect++;
      if (sect >= spt) begin
        sect = 0;
        trk++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      spt_cfg = 26;
      rt_cfg  = 2;
      spb_cfg = 8;
      sector_addr_q.delete();
      errors = 0;
      seen   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SPT: spt_cfg = 32'(pwdata[CFG_W-1:0]);
          REG_RT:  rt_cfg  = 32'(pwdata[RT_W-1:0]);
          REG_SPB: spb_cfg = 32'(pwdata[CFG_W-1:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          CMD_READ, CMD_WRITE: expand_request(s_tuser == CMD_WRITE, s_tdata[15:0],
                                              s_tdata[23:16]);
          CMD_SKEW: skew_shadow[s_tdata[29:24]] = s_tdata[37:30];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.is_write        = m_tuser;
        got.track           = m_tdata[22:0];
        got.phys_sector     = m_tdata[30:23];
        got.sector_in_block = m_tdata[36:31];
        got.last            = m_tlast;
        seen++;
        if (sector_addr_q.size() == 0) begin
          $error("sector address word with none expected: track %0d sector %0d",
                 got.track, got.phys_sector);
          errors++;
        end else begin
          want = sector_addr_q.pop_front();
          if (got.is_write !== want.is_write) begin
            $error("is_write: expected %0d, got %0d", want.is_write, got.is_write);
            errors++;
          end
          if (got.track !== want.track) begin
            $error("track: expected %0d, got %0d", want.track, got.track);
            errors++;
          end
          if (got.phys_sector !== want.phys_sector) begin
            $error("phys_sector: expected %0d, got %0d", want.phys_sector, got.phys_sector);
            errors++;
          end
          if (got.sector_in_block !== want.sector_in_block) begin
            $error("sector_in_block: expected %0d, got %0d",
                   want.sector_in_block, got.sector_in_block);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= sector_addr_q.size();
    checked    <= seen;
  end

endmodule

### verif/disk_block_sector_address_gen_tb.sv
// Testbench top for the disk block sector address generator: clock, reset, register
// writes, request words and result back-pressure; the checker module does the predicting.
// Depends on dbsa_pkg, the block and disk_block_sector_address_gen_checker.
module disk_block_sector_address_gen_tb
  import dbsa_pkg::*;
;

  // The unused command code is ignored by the block.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Settle time before a register write, covering a request that is still being worked
  // on without producing words.
  localparam int SETTLE_CYCLES = 200;
  // Watchdog limit in cycles without any accepted word or register write.
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT = 26;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]  s_tuser = CMD_READ;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int   fail_count;
  int   pending;
  int   checked;
  // While set, neither side inserts idle cycles.
  logic steady_run = 1'b0;

  int requests_sent = 0;
  int skew_loads = 0;
  int settings_used = 1;
  int stall_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  disk_block_sector_address_gen i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  disk_block_sector_address_gen_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // The result side stalls at random each cycle, except during the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: any accepted word on either channel, or a register write, counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Presents one request word and returns at the edge where it is accepted. tvalid is only
  // lowered when an idle cycle is taken, so it is never lowered and raised in one step.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BLOCK_W-1:0] blk,
                           input logic [COUNT_W-1:0] cnt, input logic [SKEW_AW-1:0] idx,
                           input logic [SKEW_W-1:0] val);
    logic [DATA_W-1:0] w;
    while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    w = '0;
    w[15:0]  = blk;
    w[23:16] = cnt;
    w[29:24] = idx;
    w[37:30] = val;
    s_tdata  <= w;
    s_tuser  <= cmd;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_SKEW) skew_loads++;
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  // Shorthand for a read or write request with random don't-care skew fields.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BLOCK_W-1:0] blk,
                              input logic [COUNT_W-1:0] cnt);
    send_word(cmd, blk, cnt, SKEW_AW'($urandom), SKEW_W'($urandom));
  endtask

  // Holds the sender off until every predicted sector address word has come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the block idle: all words back, then the settle time for a
  // request that may still be running without producing anything.
  task automatic apply_settings(input int spt, input int rt, input int spb);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SPT, spt);
    write_reg(REG_RT, rt);
    write_reg(REG_SPB, spb);
    settings_used++;
  endtask

  // Random request count: many full blocks and short runs, a few long or saturating ones.
  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return 8'(int'($urandom_range(128, 255)));
    if (roll < 35) return 8'd0;
    if (roll < 80) return 8'(int'($urandom_range(1, 16)));
    if (roll < 95) return 8'(int'($urandom_range(17, 64)));
    return 8'(int'($urandom_range(65, 127)));
  endfunction

  // One random word: mostly read and write requests, some skew reloads and unused codes.
  task automatic send_random_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) send_request(CMD_READ, BLOCK_W'($urandom), pick_count());
    else if (roll < 78) send_request(CMD_WRITE, BLOCK_W'($urandom), pick_count());
    else if (roll < 95) send_word(CMD_SKEW, BLOCK_W'($urandom), COUNT_W'($urandom),
                                  SKEW_AW'($urandom), SKEW_W'($urandom));
    else send_word(CMD_UNUSED, BLOCK_W'($urandom), COUNT_W'($urandom),
                   SKEW_AW'($urandom), SKEW_W'($urandom));
  endtask

  // Half the time the value is drawn from 0..127, which includes out-of-range values.
  function automatic int pick_cfg7();
    return ($urandom_range(1) != 0) ? int'($urandom_range(1, 64)) : int'($urandom_range(0, 127));
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The skew table powers up undefined, so every entry is loaded before any request
    // can read it. Later loads only overwrite entries.
    for (int i = 0; i < MAX_SECTORS_PER_TRACK; i++) begin
      send_word(CMD_SKEW, BLOCK_W'($urandom), COUNT_W'($urandom), SKEW_AW'(i),
                SKEW_W'($urandom_range(1, 255)));
    end

    // Directed part under the reset settings: full block, field extremes, zero count,
    // saturating counts, the most negative count, the unused code, and skew loads at both
    // ends of the table including a stored zero, which the next read then returns.
    send_request(CMD_READ, 16'd0, 8'hFF);
    send_request(CMD_WRITE, 16'hFFFF, 8'd1);
    send_request(CMD_READ, 16'd1, 8'd0);
    send_request(CMD_WRITE, 16'd3, 8'd64);
    send_request(CMD_READ, 16'd100, 8'd127);
    send_request(CMD_WRITE, 16'd7, 8'h80);
    send_word(CMD_UNUSED, 16'hFFFF, 8'hFF, 6'h3F, 8'hFF);
    send_word(CMD_SKEW, 16'hFFFF, 8'hFF, 6'd0, 8'd0);
    send_word(CMD_SKEW, 16'd0, 8'd0, 6'd63, 8'd255);
    send_request(CMD_READ, 16'd0, 8'd2);

    // Smallest legal settings: one sector per track, so every sector steps the track.
    apply_settings(1, 0, 1);
    send_request(CMD_READ, 16'd0, 8'd3);
    send_request(CMD_WRITE, 16'hFFFF, 8'hFF);

    // Largest legal settings.
    apply_settings(64, 255, 64);
    send_request(CMD_READ, 16'hFFFF, 8'hFF);
    send_request(CMD_WRITE, 16'd0, 8'd64);

    // Zero sectors per track clamps to one; zero sectors per block makes a full-block
    // request produce nothing.
    apply_settings(0, 37, 0);
    send_request(CMD_READ, 16'd1234, 8'hFF);
    send_request(CMD_WRITE, 16'd55, 8'd5);

    // Largest register values: the track clamps to 64 sectors and a full block of 127
    // sectors saturates at 64 words.
    apply_settings(127, 255, 127);
    send_request(CMD_READ, 16'd9, 8'hFF);
    send_request(CMD_WRITE, 16'hFFFF, 8'd3);

    // Random part, one register setting per phase. The third phase runs with no idle
    // cycles on either side, and halfway through one phase the sender waits for every
    // outstanding word before going on.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(pick_cfg7(), $urandom_range(0, 255), pick_cfg7());
      steady_run <= (p == 2);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (p == 4 && n == WORDS_PER_PHASE / 2) wait_for_results();
        send_random_word();
      end
    end

    wait_for_results();
    steady_run <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Drove %0d request words (%0d skew loads) over %0d register settings.",
             requests_sent, skew_loads, settings_used);
    $display("Compared %0d sector address words against the prediction.", checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
